// ===== src/lru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pkg: shared types for the LRU tag store
// Commands and controller states.
// ----------------------------------------------------------------------------
package lru_pkg;

  typedef enum logic [0:0] {
    CMD_ACCESS = 1'b0,
    CMD_PROBE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic update;
    logic out_load;
  } ctrl_t;

endpackage

// ===== src/lru_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_stream_if: valid/ready channel
// Generic payload word with handshake.
// ----------------------------------------------------------------------------
interface lru_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/lru_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_ctrl: sequencer
// Steps one word through load, lookup, update and result.
// ----------------------------------------------------------------------------
module lru_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lru_pkg::ctrl_t      ctrl
);

  lru_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lru_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctrl.load     = 1'b0;
    ctrl.update   = 1'b0;
    ctrl.out_load = 1'b0;
    unique case (state_r)
      lru_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load = 1'b1;
          state_nxt = lru_pkg::ST_LOOKUP;
        end
      end
      lru_pkg::ST_LOOKUP: begin
        state_nxt = lru_pkg::ST_UPDATE;
      end
      lru_pkg::ST_UPDATE: begin
        ctrl.update   = 1'b1;
        ctrl.out_load = 1'b1;
        state_nxt     = lru_pkg::ST_OUT;
      end
      lru_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = lru_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lru_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/lru_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_dpath: keys, recency chain and result
// Registered parallel compare, then one chain update.
// ----------------------------------------------------------------------------
module lru_dpath #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  lru_pkg::ctrl_t ctrl,
  input  logic           evict_en,
  input  logic           in_cmd,
  input  logic [31:0]    in_key,
  input  logic           in_fill_failed,
  output logic           hit,
  output logic [3:0]     slot,
  output logic           evict_valid,
  output logic [31:0]    evict_key,
  output logic           fill_request,
  output logic           status
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [LW-1:0] NONE = LW'(ENTRIES);

  logic [KEY_BITS-1:0] key_r [ENTRIES];
  logic [LW-1:0]       older_r [ENTRIES];
  logic [LW-1:0]       newer_r [ENTRIES];
  logic [IW-1:0]       front_r, back_r;

  logic                cmd_r, failed_r;
  logic [KEY_BITS-1:0] k_r;
  logic                m_r;
  logic [IW-1:0]       mi_r;

  logic                m_c;
  logic [IW-1:0]       mi_c;
  logic [KEY_BITS-1:0] kin;

  assign kin = KEY_BITS'(in_key);

  always_comb begin
    m_c  = 1'b0;
    mi_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (key_r[i] == k_r && k_r != '0) begin
        m_c  = 1'b1;
        mi_c = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r    <= in_cmd;
      k_r      <= kin;
      failed_r <= in_fill_failed;
    end
    m_r  <= m_c;
    mi_r <= mi_c;
  end

  logic          is_acc, do_front, do_miss;
  logic [IW-1:0] s;
  logic [LW-1:0] ahead, behind;

  assign is_acc   = (cmd_r == lru_pkg::CMD_ACCESS) && k_r != '0;
  assign do_miss  = is_acc && !m_r;
  assign s        = m_r ? mi_r : back_r;
  assign do_front = is_acc && (m_r || !failed_r) && s != front_r;
  assign ahead    = older_r[s];
  assign behind   = newer_r[s];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        key_r[i]   <= '0;
        older_r[i] <= (i == 0) ? NONE : LW'(i - 1);
        newer_r[i] <= (i == ENTRIES - 1) ? NONE : LW'(i + 1);
      end
      front_r <= '0;
      back_r  <= IW'(ENTRIES - 1);
    end else if (ctrl.update) begin
      if (do_miss) begin
        key_r[back_r] <= failed_r ? '0 : k_r;
      end
      if (do_front) begin
        // s is not front, so ahead is a real slot
        newer_r[ahead[IW-1:0]] <= behind;
        if (behind != NONE) begin
          older_r[behind[IW-1:0]] <= ahead;
        end else begin
          back_r <= ahead[IW-1:0];
        end
        newer_r[s]       <= LW'(front_r);
        older_r[s]       <= NONE;
        older_r[front_r] <= LW'(s);
        front_r          <= s;
      end
    end
  end

  logic [KEY_BITS-1:0] old;
  assign old = key_r[back_r];

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      hit          <= m_r && (cmd_r == lru_pkg::CMD_PROBE || k_r != '0);
      slot         <= (m_r || do_miss) ? 4'(s) : 4'd0;
      evict_valid  <= do_miss && old != '0 && evict_en;
      evict_key    <= (do_miss && old != '0 && evict_en) ? 32'(old) : 32'd0;
      fill_request <= do_miss;
      status       <= do_miss && failed_r;
    end
  end

endmodule

// ===== src/lru_cache_tag_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cache_tag_store: fully associative LRU tag store
// Key lookup, move-to-front, replacement of the least recent slot.
// ----------------------------------------------------------------------------
// One word is in flight at a time: load, a registered compare over all slots,
// one update of keys and recency links, then the result register. The result
// is held valid until out_ready takes it, and only then does the block accept
// the next word.
module lru_cache_tag_store #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_key,
  input  logic        in_fill_failed,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [3:0]  out_slot,
  output logic        out_evict_valid,
  output logic [31:0] out_evict_key,
  output logic        out_fill_request,
  output logic        out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_evict_enable
);

  lru_pkg::ctrl_t ctrl;
  logic           evict_en_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      evict_en_r <= 1'b1;
    end else if (cfg_valid) begin
      evict_en_r <= cfg_evict_enable;
    end
  end

  lru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  lru_dpath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .evict_en       (evict_en_r),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_fill_failed (in_fill_failed),
    .hit            (out_hit),
    .slot           (out_slot),
    .evict_valid    (out_evict_valid),
    .evict_key      (out_evict_key),
    .fill_request   (out_fill_request),
    .status         (out_status)
  );

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("in_ready with pending result");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |=> !in_ready) else $error("accepted while busy");
  a_hitfill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_fill_request)) else $error("hit with fill");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_fill_request) else $error("status without fill");

endmodule

// ===== tb/sv/lru_tag_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_tag_checker: scoreboard for the LRU tag store
// Watches the input, result and config channels. Keeps its own copy of the
// keys, the recency chain and evict_enable, predicts each result word, and
// compares it field by field with what the block returns, in order.
// ----------------------------------------------------------------------------
module lru_tag_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_key,
  input  logic        in_fill_failed,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_hit,
  input  logic [3:0]  out_slot,
  input  logic        out_evict_valid,
  input  logic [31:0] out_evict_key,
  input  logic        out_fill_request,
  input  logic        out_status,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_evict_enable,
  output int          fail_count,
  output int          pending,
  output int          hit_count,
  output int          miss_count
);

  localparam int SLOTS = 16;
  localparam logic [4:0] NONE = 5'd16;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        evict_valid;
    logic [31:0] evict_key;
    logic        fill_request;
    logic        status;
  } lookup_res_t;

  logic [31:0] tag_key [SLOTS];
  logic [4:0]  toward_front [SLOTS];
  logic [4:0]  toward_back [SLOTS];
  logic [4:0]  mru;
  logic [4:0]  lru;
  logic        evict_en;
  lookup_res_t expected_q[$];

  function automatic void promote(logic [4:0] s);
    logic [4:0] ahead;
    logic [4:0] behind;
    if (s == mru) return;
    ahead  = toward_front[s];
    behind = toward_back[s];
    if (ahead != NONE) toward_back[ahead] = behind;
    else mru = behind;
    if (behind != NONE) toward_front[behind] = ahead;
    else lru = ahead;
    toward_back[s]  = mru;
    toward_front[s] = NONE;
    if (mru != NONE) toward_front[mru] = s;
    mru = s;
  endfunction

  function automatic lookup_res_t predict_lookup(lru_pkg::cmd_t cmd, logic [31:0] k,
                                                 logic failed);
    lookup_res_t r;
    int m;
    r = '0;
    m = -1;
    if (k != 0)
      for (int i = 0; i < SLOTS; i++)
        if (m < 0 && tag_key[i] == k) m = i;
    if (cmd == lru_pkg::CMD_PROBE) begin
      if (m >= 0) begin
        r.hit  = 1'b1;
        r.slot = m[3:0];
      end
      return r;
    end
    if (k == 0) return r;
    if (m >= 0) begin
      r.hit  = 1'b1;
      r.slot = m[3:0];
      promote(m[4:0]);
      return r;
    end
    r.slot = lru[3:0];
    if (tag_key[lru] != 0 && evict_en) begin
      r.evict_valid = 1'b1;
      r.evict_key   = tag_key[lru];
    end
    r.fill_request = 1'b1;
    if (failed) begin
      tag_key[lru] = '0;
      r.status     = 1'b1;
      return r;
    end
    tag_key[lru] = k;
    promote(lru);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    hit_count  = 0;
    miss_count = 0;
    pending    = 0;
    for (int i = 0; i < SLOTS; i++) begin
      tag_key[i]      = '0;
      toward_front[i] = (i == 0) ? NONE : 5'(i - 1);
      toward_back[i]  = (i == SLOTS - 1) ? NONE : 5'(i + 1);
    end
    mru      = 5'd0;
    lru      = 5'(SLOTS - 1);
    evict_en = 1'b1;
  end

  always @(posedge clk) begin
    lookup_res_t got;
    lookup_res_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_hit, out_slot, out_evict_valid, out_evict_key, out_fill_request,
               out_status};
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          check_field("hit", 32'(exp_r.hit), 32'(got.hit));
          check_field("slot", 32'(exp_r.slot), 32'(got.slot));
          check_field("evict_valid", 32'(exp_r.evict_valid), 32'(got.evict_valid));
          check_field("evict_key", exp_r.evict_key, got.evict_key);
          check_field("fill_request", 32'(exp_r.fill_request), 32'(got.fill_request));
          check_field("status", 32'(exp_r.status), 32'(got.status));
          if (exp_r.hit) hit_count++;
          else miss_count++;
        end
      end
      if (in_valid && in_ready)
        expected_q.push_back(predict_lookup(lru_pkg::cmd_t'(in_cmd), in_key,
                                            in_fill_failed));
      if (cfg_valid && cfg_ready) evict_en = cfg_evict_enable;
      pending = expected_q.size();
    end
  end

  final begin
    if (expected_q.size() != 0)
      $error("%0d expected result words never arrived", expected_q.size());
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for lru_cache_tag_store
// Directed accesses and probes, then random traffic over a small key pool
// with occasional wide keys, under several idle/stall mixes and evict_enable
// settings. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic        fill_failed;
  } lookup_req_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic        evict_valid;
    logic [31:0] evict_key;
    logic        fill_request;
    logic        status;
  } lookup_rsp_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   hit_count;
  int   miss_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_left;
  bit   hold_go;
  int   words_sent;
  int   cfg_writes;
  logic [31:0] key_pool [24];

  lru_stream_if #(.payload_t(lookup_req_t)) req_ch ();
  lru_stream_if #(.payload_t(lookup_rsp_t)) rsp_ch ();
  lru_stream_if #(.payload_t(logic))        cfg_ch ();

  lru_cache_tag_store dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (req_ch.valid),
    .in_ready         (req_ch.ready),
    .in_cmd           (req_ch.data.cmd),
    .in_key           (req_ch.data.key),
    .in_fill_failed   (req_ch.data.fill_failed),
    .out_valid        (rsp_ch.valid),
    .out_ready        (rsp_ch.ready),
    .out_hit          (rsp_ch.data.hit),
    .out_slot         (rsp_ch.data.slot),
    .out_evict_valid  (rsp_ch.data.evict_valid),
    .out_evict_key    (rsp_ch.data.evict_key),
    .out_fill_request (rsp_ch.data.fill_request),
    .out_status       (rsp_ch.data.status),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_evict_enable (cfg_ch.data)
  );

  lru_tag_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (req_ch.valid),
    .in_ready         (req_ch.ready),
    .in_cmd           (req_ch.data.cmd),
    .in_key           (req_ch.data.key),
    .in_fill_failed   (req_ch.data.fill_failed),
    .out_valid        (rsp_ch.valid),
    .out_ready        (rsp_ch.ready),
    .out_hit          (rsp_ch.data.hit),
    .out_slot         (rsp_ch.data.slot),
    .out_evict_valid  (rsp_ch.data.evict_valid),
    .out_evict_key    (rsp_ch.data.evict_key),
    .out_fill_request (rsp_ch.data.fill_request),
    .out_status       (rsp_ch.data.status),
    .cfg_valid        (cfg_ch.valid),
    .cfg_ready        (cfg_ch.ready),
    .cfg_evict_enable (cfg_ch.data),
    .fail_count       (fail_count),
    .pending          (pending),
    .hit_count        (hit_count),
    .miss_count       (miss_count)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_go) begin
      hold_go   = 1'b0;
      hold_left = 60;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_word(lru_pkg::cmd_t cmd, logic [31:0] k, logic failed);
    req_ch.valid <= 1'b1;
    req_ch.data  <= '{cmd: cmd, key: k, fill_failed: failed};
    do @(posedge clk); while (!req_ch.ready);
    words_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_evict(logic en);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= en;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic random_words(int n);
    int sel;
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 80) k = key_pool[$urandom_range(23)];
      else if (sel < 97) k = $urandom() | 32'd1;
      else if (sel < 98) k = 32'hFFFF_FFFF;
      else k = '0;
      send_word(($urandom_range(99) < 25) ? lru_pkg::CMD_PROBE : lru_pkg::CMD_ACCESS, k,
                ($urandom_range(99) < 12));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    req_ch.valid   = 1'b0;
    req_ch.data    = '0;
    rsp_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    hold_go        = 1'b0;
    words_sent     = 0;
    cfg_writes     = 0;
    for (int i = 0; i < 24; i++) key_pool[i] = $urandom() | 32'd1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_word(lru_pkg::CMD_ACCESS, 32'd5, 1'b1);
    send_word(lru_pkg::CMD_ACCESS, 32'd0, 1'b0);
    send_word(lru_pkg::CMD_PROBE, 32'd0, 1'b0);
    send_word(lru_pkg::CMD_PROBE, 32'd1, 1'b0);
    for (int i = 1; i <= 17; i++)
      send_word(lru_pkg::CMD_ACCESS, (i == 16) ? 32'hFFFF_FFFF : 32'(i), 1'b0);
    send_word(lru_pkg::CMD_PROBE, 32'hFFFF_FFFF, 1'b0);
    send_word(lru_pkg::CMD_ACCESS, 32'd3, 1'b0);
    send_word(lru_pkg::CMD_ACCESS, 32'd99, 1'b1);
    drain();
    write_evict(1'b0);
    send_word(lru_pkg::CMD_ACCESS, 32'd1234, 1'b0);
    send_word(lru_pkg::CMD_ACCESS, 32'd3, 1'b0);
    drain();
    write_evict(1'b1);

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (ph == 3) hold_go = 1'b1;
      random_words(180);
      drain();
      write_evict(ph[0]);
    end

    wait (hold_left == 0);
    drain();
    $display("%0d words sent (%0d hits, %0d misses/ignored), %0d evict_enable writes",
             words_sent, hit_count, miss_count, cfg_writes);
    $display("idle/stall mixes 0/0, 86/0, 0/86, 7/7 with a long output hold-off");
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
